@@ sv/nfba_pkg.sv @@
// shared types and constants of the next-fit byte map allocator
package nfba_pkg;

   // pool geometry
   localparam int POOL_UNITS = 4096;
   localparam int MAP_AW     = $clog2(POOL_UNITS);
   localparam int RUN_W      = $clog2(POOL_UNITS + 1);

   // operation codes
   localparam logic FUNC_ALLOC = 1'b0;
   localparam logic FUNC_FREE  = 1'b1;

   // status codes
   localparam logic STATUS_OK   = 1'b0;
   localparam logic STATUS_FAIL = 1'b1;

   // request beat
   typedef struct packed {
      logic        func;
      logic [13:0] req_size;
      logic [12:0] free_addr;
   } req_type;

   // response beat
   typedef struct packed {
      logic        status;
      logic [11:0] block_start;
   } rsp_type;

   // used map access from the engine
   typedef struct packed {
      logic              wr_en;
      logic [MAP_AW-1:0] wr_addr;
      logic              wr_data;
      logic [MAP_AW-1:0] rd_addr;
   } map_cmd_type;

endpackage

@@ sv/nfba_map_ram.sv @@
// one-bit-wide used map, one write and one registered read per cycle
module nfba_map_ram
   import nfba_pkg::*;
(
   input  logic        clock,
   input  map_cmd_type map_cmd,
   output logic        rd_data
);

   logic mem [POOL_UNITS];
   logic rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (map_cmd.wr_en) begin
         mem[map_cmd.wr_addr] <= map_cmd.wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[map_cmd.rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/nfba_engine.sv @@
// sequencer for clear, next-fit scan, block marking and free over the used map
module nfba_engine
   import nfba_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        res_valid,
   input  logic        res_ready,
   output rsp_type     res_data,
   output map_cmd_type map_cmd,
   input  logic        rd_data
);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_MARK,
      ST_FREE,
      ST_REPLY
   } state_type;

   localparam logic [MAP_AW-1:0] LAST_UNIT = MAP_AW'(POOL_UNITS - 1);

   state_type         state_ff,  state_in;
   logic [MAP_AW-1:0] pos_ff,    pos_in;
   logic [MAP_AW-1:0] hint_ff,   hint_in;
   logic [RUN_W-1:0]  run_ff,    run_in;
   logic [RUN_W-1:0]  size_ff,   size_in;
   rsp_type           res_ff,    res_in;

   logic [MAP_AW-1:0] pos_next;
   logic [RUN_W-1:0]  run_base;
   logic [RUN_W-1:0]  run_new;
   logic [MAP_AW-1:0] run_begin;
   logic              size_bad;
   logic              addr_bad;

   // scan step helpers
   assign pos_next  = (pos_ff == LAST_UNIT) ? '0 : pos_ff + 1'b1;
   assign run_base  = (pos_ff == '0) ? '0 : run_ff;
   assign run_new   = rd_data ? '0 : run_base + 1'b1;
   assign run_begin = MAP_AW'(32'(pos_ff) + 32'd1 - 32'(run_new));
   assign size_bad  = (req_data.req_size == '0) || (32'(req_data.req_size) > POOL_UNITS);
   assign addr_bad  = 32'(req_data.free_addr) >= POOL_UNITS;

   assign req_stall = (state_ff != ST_IDLE);
   assign res_valid = (state_ff == ST_REPLY);
   assign res_data  = res_ff;

   // next state and map access
   always_comb begin
      state_in        = state_ff;
      pos_in          = pos_ff;
      hint_in         = hint_ff;
      run_in          = run_ff;
      size_in         = size_ff;
      res_in          = res_ff;
      map_cmd.wr_en   = 1'b0;
      map_cmd.wr_addr = pos_ff;
      map_cmd.wr_data = 1'b0;
      map_cmd.rd_addr = pos_next;

      unique case (state_ff)
         ST_CLEAR: begin
            map_cmd.wr_en = 1'b1;
            pos_in        = pos_next;
            if (pos_ff == LAST_UNIT) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            res_in = '{status: STATUS_OK, block_start: '0};
            if (req_data.func == FUNC_ALLOC) begin
               map_cmd.rd_addr = hint_ff;
            end else begin
               map_cmd.rd_addr = MAP_AW'(req_data.free_addr);
            end
            if (req_valid) begin
               if (req_data.func == FUNC_ALLOC) begin
                  pos_in  = hint_ff;
                  run_in  = '0;
                  size_in = RUN_W'(req_data.req_size);
                  if (size_bad) begin
                     res_in.status = STATUS_FAIL;
                     state_in      = ST_REPLY;
                  end else begin
                     state_in = ST_SCAN;
                  end
               end else begin
                  pos_in = MAP_AW'(req_data.free_addr);
                  if (addr_bad) begin
                     res_in.status = STATUS_FAIL;
                     state_in      = ST_REPLY;
                  end else begin
                     state_in = ST_FREE;
                  end
               end
            end
         end
         // one map unit per cycle; read of the following unit already issued
         ST_SCAN: begin
            run_in = run_new;
            pos_in = pos_next;
            priority if (pos_next == hint_ff) begin
               res_in.status = STATUS_FAIL;
               state_in      = ST_REPLY;
            end else if (run_new == size_ff) begin
               res_in.block_start = 12'(run_begin);
               hint_in            = pos_next;
               pos_in             = run_begin;
               run_in             = size_ff;
               state_in           = ST_MARK;
            end
         end
         // set used bits of the new block
         ST_MARK: begin
            map_cmd.wr_en   = 1'b1;
            map_cmd.wr_data = 1'b1;
            pos_in          = pos_next;
            run_in          = run_ff - 1'b1;
            if (run_ff == RUN_W'(1)) begin
               state_in = ST_REPLY;
            end
         end
         // clear used units upward until a free unit or the pool end
         ST_FREE: begin
            if (rd_data) begin
               map_cmd.wr_en = 1'b1;
               pos_in        = pos_next;
               if (pos_ff == LAST_UNIT) begin
                  state_in = ST_REPLY;
               end
            end else begin
               state_in = ST_REPLY;
            end
         end
         ST_REPLY: begin
            if (res_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         pos_ff   <= '0;
         hint_ff  <= '0;
      end else begin
         state_ff <= state_in;
         pos_ff   <= pos_in;
         hint_ff  <= hint_in;
      end
      run_ff  <= run_in;
      size_ff <= size_in;
      res_ff  <= res_in;
   end

endmodule

@@ sv/next_fit_byte_map_allocator.sv @@
// next-fit allocator over a one-bit used map with a roving search hint
//
// After reset the block clears the used map and stalls requests meanwhile.
// Requests are then handled one at a time. An allocate scans the map from
// the search hint one unit per cycle, up to the whole pool, and on success
// marks each unit of the new block used before it responds. A free clears
// used units upward from the freed address, one at a time, until it reads a
// free unit or reaches the pool end, and then responds. A rejected size or
// address goes straight to a fail response. Each unit is read or written on
// its own through the one-bit-wide map. A response waits in an output
// register, so the next request is taken while it is stalled.
module next_fit_byte_map_allocator
   import nfba_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   map_cmd_type map_cmd;
   logic        rd_data;
   logic        res_valid;
   logic        res_ready;
   rsp_type     res_data;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_data_ff,  rsp_data_in;

   nfba_map_ram u_map_ram (
      .clock   (clock),
      .map_cmd (map_cmd),
      .rd_data (rd_data)
   );

   nfba_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .res_valid (res_valid),
      .res_ready (res_ready),
      .res_data  (res_data),
      .map_cmd   (map_cmd),
      .rd_data   (rd_data)
   );

   // output register
   assign res_ready = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      if (res_valid && res_ready) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
